### rtl/apc_pkg.sv
package apc_pkg;

	// Conversion modes as held in the configuration register.
	typedef enum logic [1:0] {
		MODE_PREMUL   = 2'd0,
		MODE_FLATTEN  = 2'd1,
		MODE_UNPREMUL = 2'd2,
		MODE_PASS     = 2'd3
	} mode_t;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
	localparam logic [7:0] CHAN_MAX     = 8'hFF;

	// Control that travels down the pipeline next to the channel data.
	typedef struct packed {
		logic       valid;
		mode_t      mode;
		logic [7:0] alpha;
		logic       eoi;
	} stage_ctl_t;

endpackage

### rtl/apc_channel.sv
module apc_channel import apc_pkg::*; (
	input  logic       clk,
	input  stage_ctl_t ctl_s0,
	input  stage_ctl_t ctl_s1,
	input  stage_ctl_t ctl_s2,
	input  logic [7:0] chan_in,
	output logic [7:0] chan_out
);

	// Stage 0: products. The unpremultiply numerator is c*255.
	logic [15:0] prod_s0;
	logic [15:0] num_s0;
	logic        sat_s0;

	assign prod_s0 = {8'h00, chan_in} * {8'h00, ctl_s0.alpha};
	assign num_s0  = {chan_in, 8'h00} - {8'h00, chan_in};
	// When c >= a the quotient c*255/a is at least 255, so it saturates.
	assign sat_s0  = (chan_in >= ctl_s0.alpha);

	logic [7:0]  chan_s1;
	logic [15:0] prod_s1;
	logic [15:0] num_s1;
	logic        sat_s1;

	always_ff @(posedge clk) begin
		if (ctl_s0.valid) begin
			chan_s1 <= chan_in;
			prod_s1 <= prod_s0;
			num_s1  <= num_s0;
			sat_s1  <= sat_s0;
		end
	end

	// Stage 1: exact divide by 255, flatten sum, upper four quotient bits.
	logic [16:0] pm_sum;
	logic [7:0]  pm_res;
	logic [8:0]  fl_sum;
	logic [7:0]  fl_res;
	logic [7:0]  rem_a;
	logic [8:0]  trial_a;
	logic [3:0]  qhi;

	always_comb begin
		// floor(p/255) equals (p + 1 + (p >> 8)) >> 8 for every p below 65535.
		pm_sum = {1'b0, prod_s1} + 17'd1 + {9'd0, prod_s1[15:8]};
		pm_res = pm_sum[15:8];
		fl_sum = {1'b0, chan_s1} + {1'b0, ~ctl_s1.alpha};
		fl_res = fl_sum[8] ? CHAN_MAX : fl_sum[7:0];
		rem_a  = num_s1[15:8];
		qhi    = 4'd0;
		trial_a = 9'd0;
		for (int i = 0; i < 4; i++) begin
			trial_a = {rem_a, num_s1[7 - i]};
			if (trial_a >= {1'b0, ctl_s1.alpha}) begin
				trial_a     = trial_a - {1'b0, ctl_s1.alpha};
				qhi[3 - i]  = 1'b1;
			end
			rem_a = trial_a[7:0];
		end
	end

	logic [7:0] chan_s2;
	logic [7:0] pm_s2;
	logic [7:0] fl_s2;
	logic       sat_s2;
	logic [7:0] rem_s2;
	logic [3:0] qhi_s2;
	logic [3:0] numlo_s2;

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			chan_s2  <= chan_s1;
			pm_s2    <= pm_res;
			fl_s2    <= fl_res;
			sat_s2   <= sat_s1;
			rem_s2   <= rem_a;
			qhi_s2   <= qhi;
			numlo_s2 <= num_s1[3:0];
		end
	end

	// Stage 2: lower four quotient bits and the final choice of result.
	logic [7:0] rem_b;
	logic [8:0] trial_b;
	logic [3:0] qlo;
	logic [7:0] res;

	always_comb begin
		rem_b   = rem_s2;
		qlo     = 4'd0;
		trial_b = 9'd0;
		for (int i = 0; i < 4; i++) begin
			trial_b = {rem_b, numlo_s2[3 - i]};
			if (trial_b >= {1'b0, ctl_s2.alpha}) begin
				trial_b    = trial_b - {1'b0, ctl_s2.alpha};
				qlo[3 - i] = 1'b1;
			end
			rem_b = trial_b[7:0];
		end

		case (ctl_s2.mode)
			MODE_PREMUL: begin
				res = (ctl_s2.alpha == ALPHA_OPAQUE) ? chan_s2 : pm_s2;
			end
			MODE_FLATTEN: begin
				if (ctl_s2.alpha == ALPHA_CLEAR) begin
					res = CHAN_MAX;
				end else if (ctl_s2.alpha == ALPHA_OPAQUE) begin
					res = chan_s2;
				end else begin
					res = fl_s2;
				end
			end
			MODE_UNPREMUL: begin
				if (ctl_s2.alpha == ALPHA_CLEAR || ctl_s2.alpha == ALPHA_OPAQUE) begin
					res = chan_s2;
				end else if (sat_s2) begin
					res = CHAN_MAX;
				end else begin
					res = {qhi_s2, qlo};
				end
			end
			default: begin
				res = chan_s2;
			end
		endcase
	end

	logic [7:0] chan_s3;

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			chan_s3 <= res;
		end
	end

	assign chan_out = chan_s3;

endmodule

### rtl/alpha_pixel_converter_unit.sv
// Channel   | Signals                                 | Handshake
// ----------+-----------------------------------------+------------------------------
// config    | cfg_we, cfg_wdata                       | written on any edge with cfg_we
// pixel in  | start, busy, pixel_word, end_of_image   | beat taken when start && !busy
// result    | done, red, green, blue, alpha, image_end| one-cycle beat marked by done
//
// A pixel beat can be taken on every clock; busy is always low.
// Results leave in the same order as their input beats were taken.
// The pipeline has three register stages: multiply, then half of the
// bit-per-step unpremultiply divider, then the other half and the result select.
// Reset clears the mode register to premultiply and empties the pipeline.
// The receiver cannot hold off results, so the pipeline never stalls.
module alpha_pixel_converter_unit import apc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] pixel_word,
	input  logic        end_of_image,
	output logic        done,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        image_end
);

	// The conversion mode register. Writes are only expected while no beat is
	// in flight, yet the mode still rides along with each beat so that every
	// stage sees the value that was current when its pixel entered.
	mode_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PREMUL;
		end else if (cfg_we) begin
			mode_q <= mode_t'(cfg_wdata);
		end
	end

	// The pipeline has no back-pressure, so a new beat is welcome every cycle.
	assign busy = 1'b0;

	stage_ctl_t ctl_s0;
	stage_ctl_t ctl_s1;
	stage_ctl_t ctl_s2;
	stage_ctl_t ctl_s3;

	assign ctl_s0.valid = start & ~busy;
	assign ctl_s0.mode  = mode_q;
	assign ctl_s0.alpha = pixel_word[31:24];
	assign ctl_s0.eoi   = end_of_image;

	// The valid bit travels with the alpha, mode and end-of-image mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl_s0;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// One identical datapath per colour channel.
	apc_channel u_red (
		.clk      (clk),
		.ctl_s0   (ctl_s0),
		.ctl_s1   (ctl_s1),
		.ctl_s2   (ctl_s2),
		.chan_in  (pixel_word[23:16]),
		.chan_out (red)
	);

	apc_channel u_green (
		.clk      (clk),
		.ctl_s0   (ctl_s0),
		.ctl_s1   (ctl_s1),
		.ctl_s2   (ctl_s2),
		.chan_in  (pixel_word[15:8]),
		.chan_out (green)
	);

	apc_channel u_blue (
		.clk      (clk),
		.ctl_s0   (ctl_s0),
		.ctl_s1   (ctl_s1),
		.ctl_s2   (ctl_s2),
		.chan_in  (pixel_word[7:0]),
		.chan_out (blue)
	);

	// Flattening over white always yields an opaque pixel.
	assign alpha     = (ctl_s3.mode == MODE_FLATTEN) ? ALPHA_OPAQUE : ctl_s3.alpha;
	assign image_end = ctl_s3.eoi;
	assign done      = ctl_s3.valid;

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done)
		else $error("accepted pixel did not produce a result three cycles later");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3))
		else $error("result beat without a matching input beat");

	a_eoi_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (image_end == $past(end_of_image, 3)))
		else $error("end-of-image mark out of step with its pixel");

	a_alpha_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ctl_s3.mode != MODE_FLATTEN) |-> (alpha == $past(pixel_word[31:24], 3)))
		else $error("alpha changed outside flatten mode");
`endif

endmodule
